### src/csp_pkg.sv
// Shared constants, types and codes for the cardinal spline evaluator.
// No dependencies; the other files refer to this package by scoped names or import it.

package csp_pkg;

    // Store geometry: one word per coordinate, x then the y coordinates.
    localparam int MAX_POINTS  = 256;
    localparam int MAX_DIMS    = 3;
    localparam int STRIDE      = MAX_DIMS + 1;
    localparam int STORE_DEPTH = MAX_POINTS * STRIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths fixed by the interface.
    localparam int PIDX_W     = 8;
    localparam int CIDX_W     = 2;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 16;
    localparam int TEN_W      = 16;
    localparam int PCNT_W     = 9;
    localparam int DCNT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Internal arithmetic widths.
    localparam int IDX_W   = PIDX_W + 2;
    localparam int WPRE_W  = 37;
    localparam int W_W     = 25;
    localparam int PROD_W  = W_W + VAL_W;
    localparam int ACC_W   = PROD_W + 3;

    // Result queue, deep enough for every coordinate of one evaluation.
    localparam int OQ_DEPTH = MAX_DIMS + 1;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // Request codes.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TENSION     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT   = 2'd2;

    // Configuration reset values.
    localparam logic [TEN_W-1:0]  TENSION_RST     = 16'd2048;
    localparam logic [PCNT_W-1:0] POINT_COUNT_RST = 9'd1;
    localparam logic [DCNT_W-1:0] DIM_COUNT_RST   = 2'd1;

    typedef logic signed [W_W-1:0] weight_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WEIGHT,
        ST_STREAM
    } state_t;

    // Tag that travels with each store read through the MAC stages.
    typedef struct packed {
        logic              valid;
        logic [1:0]        tap;
        logic [CIDX_W-1:0] dim;
        logic              last;
    } tag_t;

    // One queued result.
    typedef struct packed {
        logic [CIDX_W-1:0]       coord;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } result_t;

endpackage

### src/csp_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on csp_pkg for field widths.

interface csp_in_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [csp_pkg::PIDX_W-1:0]       point_index;
    logic [csp_pkg::CIDX_W-1:0]       coord_index;
    logic signed [csp_pkg::VAL_W-1:0] coord_value;
    logic [csp_pkg::PIDX_W-1:0]       segment;
    logic [csp_pkg::POS_W-1:0]        position;

    modport source (
        output valid, req_type, point_index, coord_index, coord_value, segment, position,
        input  ready
    );
    modport sink (
        input  valid, req_type, point_index, coord_index, coord_value, segment, position,
        output ready
    );
endinterface

interface csp_out_if;
    logic                             valid;
    logic                             ready;
    logic [csp_pkg::CIDX_W-1:0]       out_coord;
    logic signed [csp_pkg::VAL_W-1:0] out_value;
    logic                             last;

    modport source (
        output valid, out_coord, out_value, last,
        input  ready
    );
    modport sink (
        input  valid, out_coord, out_value, last,
        output ready
    );
endinterface

### src/csp_weights.sv
// Basis weight unit: four cardinal weights from t and the tension, in registered steps.
// Depends on csp_pkg.

module csp_weights (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [csp_pkg::POS_W-1:0]         position,
    input  logic signed [csp_pkg::TEN_W-1:0]  tension,
    output csp_pkg::weight_t                  weights [4],
    output logic                              done
);

    localparam int U_W  = csp_pkg::POS_W + 3;
    localparam int V_W  = csp_pkg::POS_W + 2;
    localparam int AU_W = csp_pkg::TEN_W + U_W;
    localparam int AV_W = csp_pkg::TEN_W + V_W;
    localparam logic signed [csp_pkg::WPRE_W-1:0] W_HALF = csp_pkg::WPRE_W'(2048);
    localparam logic signed [csp_pkg::WPRE_W-1:0] W_ONE  = csp_pkg::WPRE_W'(1) <<< 28;

    logic [3:0]                        vld_reg;
    logic [csp_pkg::POS_W-1:0]         t1_reg;
    logic [csp_pkg::POS_W-1:0]         t2_reg;
    logic [csp_pkg::POS_W-1:0]         t3_reg;
    logic signed [csp_pkg::TEN_W-1:0]  a_reg;
    logic signed [AU_W-1:0]            au_reg;
    logic signed [AV_W-1:0]            av_reg;
    csp_pkg::weight_t                  w_reg [4];
    logic                              done_reg;

    logic [2*csp_pkg::POS_W-1:0]       sq;
    logic [2*csp_pkg::POS_W-1:0]       cu;
    logic signed [U_W-1:0]             u;
    logic signed [V_W-1:0]             v;
    logic signed [AU_W-1:0]            au_next;
    logic signed [AV_W-1:0]            av_next;
    logic signed [csp_pkg::WPRE_W-1:0] au_e;
    logic signed [csp_pkg::WPRE_W-1:0] av_e;
    logic signed [csp_pkg::WPRE_W-1:0] t_term;
    logic signed [csp_pkg::WPRE_W-1:0] pre [4];
    logic signed [csp_pkg::WPRE_W-1:0] pre_rnd [4];

    // Powers of t and the two tension products.
    always_comb
    begin
        sq = t1_reg * t1_reg;
        cu = t2_reg * t1_reg;
        u = $signed(U_W'(t3_reg)) - $signed(U_W'({t2_reg, 1'b0})) + $signed(U_W'(t1_reg));
        v = $signed(V_W'(t3_reg)) - $signed(V_W'(t2_reg));
        au_next = a_reg * u;
        av_next = a_reg * v;
    end

    // Weights in Q.28: w0 = -a*u, w1 = -a*v + k + 2^28, w2 = a*u - k, w3 = a*v,
    // with k = 8192*t3 - 12288*t2.
    always_comb
    begin
        au_e = csp_pkg::WPRE_W'(au_reg);
        av_e = csp_pkg::WPRE_W'(av_reg);
        t_term = ($signed(csp_pkg::WPRE_W'(t3_reg)) <<< 13)
               - ($signed(csp_pkg::WPRE_W'(t2_reg)) <<< 13)
               - ($signed(csp_pkg::WPRE_W'(t2_reg)) <<< 12);
        pre[0] = -au_e;
        pre[1] = t_term - av_e + W_ONE;
        pre[2] = au_e - t_term;
        pre[3] = av_e;
        for (int i = 0; i < 4; i++)
        begin
            pre_rnd[i] = (pre[i] + W_HALF) >>> 12;
        end
    end

    // Step sequence and the done flag, cleared by each start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], start};
            if (start)
                done_reg <= 1'b0;
            else if (vld_reg[3])
                done_reg <= 1'b1;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            t1_reg <= position;
            a_reg  <= tension;
        end
        if (vld_reg[0])
            t2_reg <= sq[2*csp_pkg::POS_W-1:csp_pkg::POS_W];
        if (vld_reg[1])
            t3_reg <= cu[2*csp_pkg::POS_W-1:csp_pkg::POS_W];
        if (vld_reg[2])
        begin
            au_reg <= au_next;
            av_reg <= av_next;
        end
        if (vld_reg[3])
        begin
            for (int i = 0; i < 4; i++)
            begin
                w_reg[i] <= pre_rnd[i][csp_pkg::W_W-1:0];
            end
        end
    end

    assign weights = w_reg;
    assign done    = done_reg;

endmodule

### src/cardinal_spline_evaluator.sv
// Cardinal spline evaluator: an evaluate transfer holds off further requests while the
// weights are formed, any earlier results leave and the store is read; a load does not.
// The single-port point store sets the rate: one point word is read per cycle.
// One result is queued per coordinate, x first, once its four taps are accumulated.
// Reset clears control state and sets the registers to their defaults; the store is not cleared.
// Depends on csp_pkg, csp_if and csp_weights.

module cardinal_spline_evaluator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [csp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csp_pkg::CFG_DATA_W-1:0]      cfg_data,
    csp_in_if.sink                              in_ch,
    csp_out_if.source                           out_ch
);

    localparam logic signed [csp_pkg::ACC_W-1:0] R_HALF = csp_pkg::ACC_W'(32768);

    // Configuration registers.
    logic signed [csp_pkg::TEN_W-1:0] tension_reg;
    logic [csp_pkg::PCNT_W-1:0]       pcount_reg;
    logic [csp_pkg::DCNT_W-1:0]       dcount_reg;

    // Control.
    csp_pkg::state_t                  state_reg;
    csp_pkg::state_t                  state_next;
    logic [3:0]                       cnt_reg;
    logic [3:0]                       cnt_next;
    logic [csp_pkg::PIDX_W-1:0]       seg_reg;
    logic [csp_pkg::PIDX_W-1:0]       hi_reg;
    logic [csp_pkg::CIDX_W-1:0]       dims_reg;
    logic [csp_pkg::PIDX_W-1:0]       hi_next;
    logic [csp_pkg::CIDX_W-1:0]       dims_next;

    logic in_fire;
    logic eval_start;
    logic mem_we;
    logic mem_re;
    logic [csp_pkg::ADDR_W-1:0] mem_addr;
    logic [csp_pkg::ADDR_W-1:0] rd_addr;
    logic [csp_pkg::ADDR_W-1:0] wr_addr;

    // Weight unit.
    csp_pkg::weight_t weights [4];
    logic             w_done;

    // Store and MAC pipeline.
    logic [csp_pkg::VAL_W-1:0]        store_mem [csp_pkg::STORE_DEPTH];
    logic signed [csp_pkg::VAL_W-1:0] rd_reg;
    logic signed [csp_pkg::PROD_W-1:0] prod_reg;
    logic signed [csp_pkg::PROD_W-1:0] prod_next;
    logic signed [csp_pkg::ACC_W-1:0]  acc_reg;
    logic signed [csp_pkg::ACC_W-1:0]  acc_next;
    csp_pkg::tag_t                    s1_reg;
    csp_pkg::tag_t                    s2_reg;
    csp_pkg::tag_t                    s3_reg;
    csp_pkg::tag_t                    s1_next;

    // Round and saturate.
    logic signed [csp_pkg::ACC_W-1:0] rnd;
    logic signed [csp_pkg::VAL_W-1:0] sat_val;
    logic                             fits;

    // Result queue.
    csp_pkg::result_t                 oq_mem [csp_pkg::OQ_DEPTH];
    logic [csp_pkg::OQ_PTR_W-1:0]     wr_ptr_reg;
    logic [csp_pkg::OQ_PTR_W-1:0]     rd_ptr_reg;
    logic [csp_pkg::OQ_CNT_W-1:0]     ocnt_reg;
    logic                             oq_wr;
    logic                             oq_rd;

    // Clamped point index for the current read.
    logic signed [csp_pkg::IDX_W-1:0] idx_full;
    logic [csp_pkg::PIDX_W-1:0]       idx_clamped;
    logic                             load_ok;

    assign in_fire    = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == csp_pkg::ST_IDLE);
    assign eval_start = in_fire && (in_ch.req_type == csp_pkg::REQ_EVAL);

    // A load outside the store is dropped.
    assign load_ok = (32'(in_ch.point_index) < csp_pkg::MAX_POINTS)
                  && (32'(in_ch.coord_index) <= csp_pkg::MAX_DIMS);
    assign mem_we  = in_fire && (in_ch.req_type == csp_pkg::REQ_LOAD) && load_ok;
    assign mem_re  = (state_reg == csp_pkg::ST_STREAM);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg <= csp_pkg::TENSION_RST;
            pcount_reg  <= csp_pkg::POINT_COUNT_RST;
            dcount_reg  <= csp_pkg::DIM_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csp_pkg::CFG_TENSION:     tension_reg <= cfg_data;
                csp_pkg::CFG_POINT_COUNT: pcount_reg  <= cfg_data[csp_pkg::PCNT_W-1:0];
                csp_pkg::CFG_DIM_COUNT:   dcount_reg  <= cfg_data[csp_pkg::DCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp bound and coordinate count for the next evaluation.
    always_comb
    begin
        if (pcount_reg == '0)
            hi_next = '0;
        else if (32'(pcount_reg) > csp_pkg::MAX_POINTS)
            hi_next = csp_pkg::PIDX_W'(csp_pkg::MAX_POINTS - 1);
        else
            hi_next = csp_pkg::PIDX_W'(pcount_reg - 1'b1);
        if (32'(dcount_reg) > csp_pkg::MAX_DIMS)
            dims_next = csp_pkg::CIDX_W'(csp_pkg::MAX_DIMS);
        else
            dims_next = csp_pkg::CIDX_W'(dcount_reg);
    end

    csp_weights u_weights (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (eval_start),
        .position (in_ch.position),
        .tension  (tension_reg),
        .weights  (weights),
        .done     (w_done)
    );

    // Sequencer: wait for weights and an empty result path, then stream the reads.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            csp_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (eval_start)
                    state_next = csp_pkg::ST_WEIGHT;
            end
            csp_pkg::ST_WEIGHT:
            begin
                if (w_done && (ocnt_reg == '0) && !s1_reg.valid && !s2_reg.valid
                    && !s3_reg.valid)
                    state_next = csp_pkg::ST_STREAM;
            end
            csp_pkg::ST_STREAM:
            begin
                cnt_next = cnt_reg + 1'b1;
                if ((cnt_reg[3:2] == dims_reg) && (cnt_reg[1:0] == 2'd3))
                    state_next = csp_pkg::ST_IDLE;
            end
            default:
                state_next = csp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csp_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_start)
        begin
            seg_reg  <= in_ch.segment;
            hi_reg   <= hi_next;
            dims_reg <= dims_next;
        end
    end

    // Read address: point k + tap - 1, clamped to the loaded range.
    always_comb
    begin
        idx_full = $signed(csp_pkg::IDX_W'(seg_reg)) + $signed(csp_pkg::IDX_W'(cnt_reg[1:0]))
                 - csp_pkg::IDX_W'(1);
        if (idx_full < 0)
            idx_clamped = '0;
        else if (idx_full > $signed(csp_pkg::IDX_W'(hi_reg)))
            idx_clamped = hi_reg;
        else
            idx_clamped = idx_full[csp_pkg::PIDX_W-1:0];
        rd_addr = csp_pkg::ADDR_W'(idx_clamped) * csp_pkg::ADDR_W'(csp_pkg::STRIDE)
                + csp_pkg::ADDR_W'(cnt_reg[3:2]);
        wr_addr = csp_pkg::ADDR_W'(in_ch.point_index) * csp_pkg::ADDR_W'(csp_pkg::STRIDE)
                + csp_pkg::ADDR_W'(in_ch.coord_index);
        mem_addr = mem_we ? wr_addr : rd_addr;
    end

    // Single-port point store.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_addr] <= in_ch.coord_value;
        else if (mem_re)
            rd_reg <= store_mem[mem_addr];
    end

    // Tag for the word being read.
    always_comb
    begin
        s1_next.valid = mem_re;
        s1_next.tap   = cnt_reg[1:0];
        s1_next.dim   = cnt_reg[3:2];
        s1_next.last  = (cnt_reg[3:2] == dims_reg);
    end

    // Multiply, then accumulate the four taps of each coordinate.
    always_comb
    begin
        prod_next = weights[s1_reg.tap] * rd_reg;
        if (s2_reg.tap == 2'd0)
            acc_next = csp_pkg::ACC_W'(prod_reg);
        else
            acc_next = acc_reg + csp_pkg::ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else
        begin
            s1_reg       <= s1_next;
            s2_reg       <= s1_reg;
            s3_reg.valid <= s2_reg.valid && (s2_reg.tap == 2'd3);
            s3_reg.tap   <= s2_reg.tap;
            s3_reg.dim   <= s2_reg.dim;
            s3_reg.last  <= s2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_reg.valid)
            prod_reg <= prod_next;
        if (s2_reg.valid)
            acc_reg <= acc_next;
    end

    // Round to Q16.16 and saturate to 32 bits.
    always_comb
    begin
        rnd  = (acc_reg + R_HALF) >>> 16;
        fits = (rnd[csp_pkg::ACC_W-1:csp_pkg::VAL_W-1] == '0)
            || (rnd[csp_pkg::ACC_W-1:csp_pkg::VAL_W-1] == '1);
        if (fits)
            sat_val = rnd[csp_pkg::VAL_W-1:0];
        else if (rnd[csp_pkg::ACC_W-1])
            sat_val = {1'b1, {(csp_pkg::VAL_W-1){1'b0}}};
        else
            sat_val = {1'b0, {(csp_pkg::VAL_W-1){1'b1}}};
    end

    // Result queue between the datapath and the output channel.
    assign oq_wr = s3_reg.valid;
    assign oq_rd = out_ch.valid && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            ocnt_reg   <= '0;
        end
        else
        begin
            if (oq_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (oq_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (oq_wr && !oq_rd)
                ocnt_reg <= ocnt_reg + 1'b1;
            else if (!oq_wr && oq_rd)
                ocnt_reg <= ocnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_wr)
        begin
            oq_mem[wr_ptr_reg].coord <= s3_reg.dim;
            oq_mem[wr_ptr_reg].value <= sat_val;
            oq_mem[wr_ptr_reg].last  <= s3_reg.last;
        end
    end

    assign out_ch.valid     = (ocnt_reg != '0);
    assign out_ch.out_coord = oq_mem[rd_ptr_reg].coord;
    assign out_ch.out_value = oq_mem[rd_ptr_reg].value;
    assign out_ch.last      = oq_mem[rd_ptr_reg].last;

`ifndef SYNTHESIS
    // The queue never takes a result when it is full.
    a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        oq_wr |-> (32'(ocnt_reg) < csp_pkg::OQ_DEPTH) || oq_rd)
        else $error("result queue overflow");

    // Streaming only runs on finished weights.
    a_stream_weights: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csp_pkg::ST_STREAM) |-> w_done)
        else $error("streaming without valid weights");

    // A read marked as the final coordinate belongs to the last coordinate index.
    a_last_coord: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid && s1_reg.last |-> (s1_reg.dim == dims_reg))
        else $error("last flag on wrong coordinate");

    // A store write never collides with a streamed read.
    a_no_write_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == csp_pkg::ST_IDLE))
        else $error("store written during an evaluation");
`endif

endmodule

### test/spline_checker.sv
// Checker for the cardinal spline evaluator: mirrors the registers and the point store,
// predicts each evaluation's coordinates and compares them with the result channel.
// Depends on csp_pkg and on the channel interfaces in csp_if.

module spline_checker
    import csp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    csp_in_if                     in_ch,
    csp_out_if                    out_ch,
    output int                    mismatches,
    output int                    outstanding
);

    // Matrix constants in Q4.12 and the signed 32-bit bounds of a result.
    localparam longint ONE_Q12   = 4096;
    localparam longint TWO_Q12   = 8192;
    localparam longint THREE_Q12 = 12288;
    localparam longint SAT_HI    = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO    = -SAT_HI - 1;
    localparam int     REPORT_MAX = 10;

    logic [VAL_W-1:0]        coord_mem [STORE_DEPTH];
    logic signed [TEN_W-1:0] tension_q;
    logic [PCNT_W-1:0]       pcount_q;
    logic [DCNT_W-1:0]       dcount_q;
    result_t                 curve_q [$];

    initial
    begin
        mismatches = 0;
    end

    // Queue every coordinate that one evaluation should produce, x first.
    function automatic void predict_curve(input logic [PIDX_W-1:0] seg,
                                          input logic [POS_W-1:0] pos);
        longint  a, t1, t2, t3, acc, r, hi, idx;
        longint  coef [4];
        longint  wt [4];
        int      dims;
        result_t res;
        t1 = longint'(pos);
        t2 = (t1 * t1) >>> 16;
        t3 = (t2 * t1) >>> 16;
        a  = longint'(tension_q);

        // Basis weights, exact in Q.28, then rounded to Q.16.
        coef[0] = -a * t3 + 2 * a * t2 - a * t1;
        coef[1] = (TWO_Q12 - a) * t3 + (a - THREE_Q12) * t2 + ONE_Q12 * 65536;
        coef[2] = (a - TWO_Q12) * t3 + (THREE_Q12 - 2 * a) * t2 + a * t1;
        coef[3] = a * t3 - a * t2;
        for (int i = 0; i < 4; i++)
        begin
            wt[i] = (coef[i] + 2048) >>> 12;
        end

        // Upper clamp bound: a zero count acts as one point, an oversize count as the store.
        hi = (longint'(pcount_q) > MAX_POINTS) ? MAX_POINTS : longint'(pcount_q);
        hi = (hi > 0) ? hi - 1 : 0;
        dims = (int'(dcount_q) > MAX_DIMS) ? MAX_DIMS : int'(dcount_q);

        for (int d = 0; d <= dims; d++)
        begin
            acc = 0;
            for (int i = 0; i < 4; i++)
            begin
                idx = longint'(seg) + i - 1;
                if (idx < 0)
                    idx = 0;
                if (idx > hi)
                    idx = hi;
                acc += wt[i] * longint'($signed(coord_mem[int'(idx) * STRIDE + d]));
            end
            r = (acc + 32768) >>> 16;
            if (r > SAT_HI)
                r = SAT_HI;
            if (r < SAT_LO)
                r = SAT_LO;
            res.coord = CIDX_W'(d);
            res.value = r[VAL_W-1:0];
            res.last  = (d == dims);
            curve_q.push_back(res);
        end
    endfunction

    // Count a failure; only the first few are described in full.
    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] result check failed: %s", $realtime, what);
    endfunction

    // Compare one result transfer with the oldest prediction.
    function automatic void check_result();
        result_t want;
        if (curve_q.size() == 0)
        begin
            note_mismatch($sformatf("unexpected result coord %0d value %0d last %0d",
                                    out_ch.out_coord, out_ch.out_value, out_ch.last));
        end
        else
        begin
            want = curve_q.pop_front();
            if (out_ch.out_coord !== want.coord || out_ch.out_value !== want.value ||
                out_ch.last !== want.last)
                note_mismatch($sformatf(
                    "expected coord %0d value %0d last %0d, got coord %0d value %0d last %0d",
                    want.coord, want.value, want.last,
                    out_ch.out_coord, out_ch.out_value, out_ch.last));
        end
    endfunction

    // Register writes, store loads and evaluations are taken in that order at each edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_q.delete();
            tension_q = TENSION_RST;
            pcount_q  = POINT_COUNT_RST;
            dcount_q  = DIM_COUNT_RST;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we === 1'b1)
            begin
                case (cfg_index)
                    CFG_TENSION:     tension_q = cfg_data[TEN_W-1:0];
                    CFG_POINT_COUNT: pcount_q  = cfg_data[PCNT_W-1:0];
                    CFG_DIM_COUNT:   dcount_q  = cfg_data[DCNT_W-1:0];
                    default:         ;
                endcase
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            begin
                if (in_ch.req_type == REQ_LOAD)
                    coord_mem[int'(in_ch.point_index) * STRIDE + int'(in_ch.coord_index)] =
                        in_ch.coord_value;
                else
                    predict_curve(in_ch.segment, in_ch.position);
            end
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                check_result();
            outstanding <= curve_q.size();
        end
    end

endmodule

### test/tb.sv
// Top of the cardinal spline evaluator testbench: clock, reset, register writes, request
// stimulus, random back-pressure, a stall watchdog and the verdict.
// Depends on csp_pkg, csp_if, the evaluator RTL and spline_checker.

module tb;
    import csp_pkg::*;

    // Longest stretch with no transfer on either channel before the run is abandoned.
    // A correct run stays far below it, even with the settle pause and random stalls at 69 percent.
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE      = 32;
    localparam int BLOCK_ITEMS = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    csp_in_if  in_ch();
    csp_out_if out_ch();

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;
    int send_idle    = 0;
    int recv_idle    = 0;
    int items_sent   = 0;
    int pcount_set;
    int dims_set;
    int goal;
    bit loaded [MAX_POINTS][STRIDE];

    cardinal_spline_evaluator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    spline_checker u_spline_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Random back-pressure on the result channel.
    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Highest point index that the clamp can reach under the current count.
    function automatic int window_top();
        int hi;
        hi = (pcount_set > MAX_POINTS) ? MAX_POINTS : pcount_set;
        return (hi > 0) ? hi - 1 : 0;
    endfunction

    function automatic logic [VAL_W-1:0] rand_coord();
        case ($urandom_range(0, 19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return POS_W'($urandom);
        endcase
    endfunction

    // Mostly segments around the loaded range, sometimes anywhere.
    function automatic logic [PIDX_W-1:0] pick_segment();
        int span;
        span = window_top() + 2;
        if (span > 255)
            span = 255;
        if ($urandom_range(0, 9) < 7)
            return PIDX_W'($urandom_range(0, span));
        return PIDX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [PIDX_W-1:0] pick_point();
        if ($urandom_range(0, 1) == 0)
            return PIDX_W'($urandom_range(0, window_top()));
        return PIDX_W'($urandom_range(0, 255));
    endfunction

    // One request transfer, with a random gap before it; valid stays high afterwards.
    task automatic push_req(input logic rt, input logic [PIDX_W-1:0] pidx,
                            input logic [CIDX_W-1:0] cidx, input logic [VAL_W-1:0] val,
                            input logic [PIDX_W-1:0] seg, input logic [POS_W-1:0] pos);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= rt;
        in_ch.point_index <= pidx;
        in_ch.coord_index <= cidx;
        in_ch.coord_value <= val;
        in_ch.segment     <= seg;
        in_ch.position    <= pos;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic load_coord(input int p, input int c, input logic [VAL_W-1:0] val);
        push_req(REQ_LOAD, PIDX_W'(p), CIDX_W'(c), val, PIDX_W'($urandom), POS_W'($urandom));
        loaded[p][c] = 1'b1;
    endtask

    // Load any coordinate that an evaluation of this segment would read but that was never
    // written, so the block never reads an undefined store word.
    task automatic evaluate(input logic [PIDX_W-1:0] seg, input logic [POS_W-1:0] pos);
        int hi;
        int idx;
        hi = window_top();
        for (int i = -1; i <= 2; i++)
        begin
            idx = int'(seg) + i;
            if (idx < 0)
                idx = 0;
            if (idx > hi)
                idx = hi;
            for (int c = 0; c <= dims_set; c++)
            begin
                if (!loaded[idx][c])
                    load_coord(idx, c, rand_coord());
            end
        end
        push_req(REQ_EVAL, PIDX_W'($urandom), CIDX_W'($urandom), $urandom, seg, pos);
    endtask

    // Hold off until every predicted result has arrived and the block has settled.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] ten,
                              input logic [CFG_DATA_W-1:0] pcw,
                              input logic [CFG_DATA_W-1:0] dcw);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TENSION;
        cfg_data  <= ten;
        @(posedge clk);
        cfg_index <= CFG_POINT_COUNT;
        cfg_data  <= pcw;
        @(posedge clk);
        cfg_index <= CFG_DIM_COUNT;
        cfg_data  <= dcw;
        @(posedge clk);
        cfg_we <= 1'b0;
        pcount_set = int'(pcw[PCNT_W-1:0]);
        dims_set   = int'(dcw[DCNT_W-1:0]);
    endtask

    task automatic random_regs();
        logic [CFG_DATA_W-1:0] ten;
        logic [CFG_DATA_W-1:0] pcw;
        logic [CFG_DATA_W-1:0] dcw;
        case ($urandom_range(0, 9))
            0:       ten = 16'h7FFF;
            1:       ten = 16'h8000;
            2:       ten = 16'd2048;
            default: ten = CFG_DATA_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       pcw = 16'd0;
            1:       pcw = 16'd256;
            2:       pcw = CFG_DATA_W'($urandom_range(257, 511));
            3:       pcw = CFG_DATA_W'($urandom_range(9, 255));
            default: pcw = CFG_DATA_W'($urandom_range(1, 8));
        endcase
        dcw = CFG_DATA_W'($urandom_range(0, 3));
        // Bits above each register's width should have no effect.
        if ($urandom_range(0, 3) == 0)
            pcw[CFG_DATA_W-1:PCNT_W] = 7'($urandom);
        if ($urandom_range(0, 3) == 0)
            dcw[CFG_DATA_W-1:DCNT_W] = 14'($urandom);
        write_regs(ten, pcw, dcw);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_TENSION;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.req_type    = REQ_LOAD;
        in_ch.point_index = '0;
        in_ch.coord_index = '0;
        in_ch.coord_value = '0;
        in_ch.segment     = '0;
        in_ch.position    = '0;
        out_ch.ready      = 1'b0;
        pcount_set        = int'(POINT_COUNT_RST);
        dims_set          = int'(DIM_COUNT_RST);
        send_idle         = 9;
        recv_idle         = 69;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: tension one half, a single point, one y coordinate.
        load_coord(0, 0, 32'h7FFF_FFFF);
        load_coord(0, 1, 32'h8000_0000);
        evaluate(8'd0, 16'h0000);
        evaluate(8'd255, 16'hFFFF);
        drain();

        // Strongest tension, four points, x alone; alternating extremes drive saturation.
        write_regs(16'h7FFF, 16'd4, 16'd0);
        load_coord(1, 0, 32'h8000_0000);
        load_coord(2, 0, 32'h7FFF_FFFF);
        load_coord(3, 0, 32'h8000_0000);
        evaluate(8'd1, 16'h8000);
        evaluate(8'd2, 16'hFFFF);
        drain();

        // Most negative tension and a zero point count, so every index clamps to point 0.
        write_regs(16'h8000, 16'd0, 16'd3);
        load_coord(0, 2, 32'h0000_0001);
        load_coord(0, 3, 32'hFFFF_FFFF);
        evaluate(8'd7, 16'h0001);
        drain();

        // Zero tension, a count beyond the store, both ends of the table.
        write_regs(16'h0000, 16'h01FF, 16'd2);
        evaluate(8'd255, 16'h8000);
        evaluate(8'd0, 16'h4000);

        // Random part: three back-pressure regimes, each over several register settings.
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle = 9;
                    recv_idle = 69;
                end
                1:
                begin
                    send_idle = 69;
                    recv_idle = 9;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (int blk = 0; blk < 3; blk++)
            begin
                drain();
                random_regs();
                goal = items_sent + BLOCK_ITEMS;
                while (items_sent < goal)
                begin
                    if ($urandom_range(0, 99) < 80)
                        evaluate(pick_segment(), pick_position());
                    else
                        load_coord(int'(pick_point()), $urandom_range(0, 3), rand_coord());
                    if ($urandom_range(0, 99) < 4)
                        drain();
                end
            end
        end

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
